FILE: rtl/sit_pkg.sv
// Shared constants and types for the stable sorted insertion table.
package sit_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int KEY_BITS_DEF    = 32;
  localparam int REF_BITS_DEF    = 16;
  localparam int OP_W            = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  // Broadcast control for one cell of the chain.
  typedef struct packed {
    logic ins;   // insert beat accepted and table not full
    logic occ;   // cell holds a live entry
  } cell_ctl_t;

endpackage

FILE: rtl/sit_cell.sv
// One slot of the insertion chain: compare, shift right or load the new entry.
module sit_cell #(
  parameter int KEY_BITS = sit_pkg::KEY_BITS_DEF,
  parameter int REF_BITS = sit_pkg::REF_BITS_DEF
) (
  input  logic                clk,
  input  sit_pkg::cell_ctl_t  ctl,
  input  logic [KEY_BITS-1:0] new_key,
  input  logic [REF_BITS-1:0] new_ref,
  input  logic                new_ret,
  input  logic                prv_shift,
  input  logic [KEY_BITS-1:0] prv_key,
  input  logic [REF_BITS-1:0] prv_ref,
  input  logic                prv_ret,
  output logic                shift_out,
  output logic [KEY_BITS-1:0] key_q,
  output logic [REF_BITS-1:0] ref_q,
  output logic                ret_q
);
  import sit_pkg::*;

  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [REF_BITS-1:0] ref_r, ref_nxt;
  logic                ret_r, ret_nxt;

  // Live entry strictly above the new key moves one slot toward the tail.
  assign shift_out = ctl.occ && (key_r > new_key);

  always_comb begin
    key_nxt = key_r;
    ref_nxt = ref_r;
    ret_nxt = ret_r;
    if (ctl.ins) begin
      if (prv_shift) begin
        key_nxt = prv_key;
        ref_nxt = prv_ref;
        ret_nxt = prv_ret;
      end else if (shift_out || !ctl.occ) begin
        // free slots past the tail may take a copy; only the first one counts
        key_nxt = new_key;
        ref_nxt = new_ref;
        ret_nxt = new_ret;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    ref_r <= ref_nxt;
    ret_r <= ret_nxt;
  end

  assign key_q = key_r;
  assign ref_q = ref_r;
  assign ret_q = ret_r;

endmodule

FILE: rtl/stable_sorted_insert_table.sv
// Top level of the stable sorted insertion table: cell chain, count and result register.
// A result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle for every op unless out_tready stalls; all cells
//   compare with the broadcast key and shift in the same cycle, so inserts never iterate.
// Reset (rst_n low, synchronous): empties the table and drops any pending
//   result beat; entry storage itself is not cleared.
module stable_sorted_insert_table #(
  parameter  int TABLE_DEPTH = sit_pkg::TABLE_DEPTH_DEF,
  parameter  int KEY_BITS    = sit_pkg::KEY_BITS_DEF,
  parameter  int REF_BITS    = sit_pkg::REF_BITS_DEF,
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1),
  localparam int IN_W        = sit_pkg::OP_W + KEY_BITS + REF_BITS + 1 + CNT_W,
  localparam int OUT_W       = CNT_W + 1 + KEY_BITS + REF_BITS + 1 + 1,
  localparam int IN_TW       = ((IN_W + 7) / 8) * 8,
  localparam int OUT_TW      = ((OUT_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // fields from bit 0: op, date_key, loan_ref, returned_in, position, zero pad
  input  logic [IN_TW-1:0]  in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // fields from bit 0: entry_count, found, key_out, ref_out, returned_out,
  // full_reject, zero pad
  output logic [OUT_TW-1:0] out_tdata
);
  import sit_pkg::*;

  localparam int KEY_LO = OP_W;
  localparam int REF_LO = KEY_LO + KEY_BITS;
  localparam int RET_LO = REF_LO + REF_BITS;
  localparam int POS_LO = RET_LO + 1;

  // unpack the input beat
  logic [OP_W-1:0]     in_op;
  logic [KEY_BITS-1:0] in_key;
  logic [REF_BITS-1:0] in_ref;
  logic                in_ret;
  logic [CNT_W-1:0]    in_pos;

  assign in_op  = in_tdata[OP_W-1:0];
  assign in_key = in_tdata[REF_LO-1:KEY_LO];
  assign in_ref = in_tdata[RET_LO-1:REF_LO];
  assign in_ret = in_tdata[RET_LO];
  assign in_pos = in_tdata[POS_LO+CNT_W-1:POS_LO];

  logic accept;
  logic out_valid_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic full;

  // Take a new beat whenever the result register is empty or being drained;
  // hold off while reset is applied.
  assign in_tready = rst_n && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign full      = (count_r == CNT_W'(TABLE_DEPTH));

  logic is_ins, is_rd, is_clr;
  always_comb begin
    is_ins = 1'b0;
    is_rd  = 1'b0;
    is_clr = 1'b0;
    case (op_t'(in_op))
      OP_INSERT: is_ins = 1'b1;
      OP_READ:   is_rd  = 1'b1;
      OP_CLEAR:  is_clr = 1'b1;
      default:   ;
    endcase
  end

  logic do_ins;
  assign do_ins = accept && is_ins && !full;

  // ---------------- cell chain ----------------
  logic [TABLE_DEPTH-1:0] shift_w;
  logic [TABLE_DEPTH-1:0] occ_w;
  logic [TABLE_DEPTH-1:0] hit_w;
  logic [KEY_BITS-1:0]    key_w [TABLE_DEPTH];
  logic [REF_BITS-1:0]    ref_w [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] ret_w;

  // read index: position zero acts as position one
  logic [CNT_W-1:0] rd_idx;
  assign rd_idx = (in_pos == '0) ? '0 : in_pos - CNT_W'(1);

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    cell_ctl_t ctl;
    logic                pshift;
    logic [KEY_BITS-1:0] pkey;
    logic [REF_BITS-1:0] pref;
    logic                pret;

    assign occ_w[i] = (CNT_W'(i) < count_r);
    assign hit_w[i] = (rd_idx == CNT_W'(i));
    assign ctl.ins  = do_ins;
    assign ctl.occ  = occ_w[i];

    if (i == 0) begin : g_head
      // head cell has no left neighbor
      assign pshift = 1'b0;
      assign pkey   = in_key;
      assign pref   = in_ref;
      assign pret   = in_ret;
    end else begin : g_body
      assign pshift = shift_w[i-1];
      assign pkey   = key_w[i-1];
      assign pref   = ref_w[i-1];
      assign pret   = ret_w[i-1];
    end

    sit_cell #(
      .KEY_BITS (KEY_BITS),
      .REF_BITS (REF_BITS)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .new_key   (in_key),
      .new_ref   (in_ref),
      .new_ret   (in_ret),
      .prv_shift (pshift),
      .prv_key   (pkey),
      .prv_ref   (pref),
      .prv_ret   (pret),
      .shift_out (shift_w[i]),
      .key_q     (key_w[i]),
      .ref_q     (ref_w[i]),
      .ret_q     (ret_w[i])
    );
  end

  // Select the addressed cell: one-hot AND-OR across the row.
  logic [KEY_BITS-1:0] sel_key;
  logic [REF_BITS-1:0] sel_ref;
  logic                sel_ret;
  always_comb begin
    sel_key = '0;
    sel_ref = '0;
    sel_ret = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      sel_key = sel_key | (key_w[i] & {KEY_BITS{hit_w[i]}});
      sel_ref = sel_ref | (ref_w[i] & {REF_BITS{hit_w[i]}});
      sel_ret = sel_ret | (ret_w[i] & hit_w[i]);
    end
  end

  // ---------------- count ----------------
  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      if (do_ins) begin
        count_nxt = count_r + CNT_W'(1);
      end else if (is_clr) begin
        count_nxt = '0;
      end
    end
  end

  // ---------------- result register ----------------
  logic                found_nxt, found_r;
  logic [KEY_BITS-1:0] okey_r;
  logic [REF_BITS-1:0] oref_r;
  logic                oret_r;
  logic                rej_r;
  logic [CNT_W-1:0]    ocnt_r;

  assign found_nxt = is_rd && (rd_idx < count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: load on accept, hold while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      ocnt_r  <= count_nxt;
      found_r <= found_nxt;
      okey_r  <= found_nxt ? sel_key : '0;
      oref_r  <= found_nxt ? sel_ref : '0;
      oret_r  <= found_nxt && sel_ret;
      rej_r   <= is_ins && full;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TW'({rej_r, oret_r, oref_r, okey_r, found_r, ocnt_r});

  // ---------------- checks ----------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_clr) |=> (count_r == '0))
    else $error("clear did not empty the table");

  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rej_r) |-> (ocnt_r == CNT_W'(TABLE_DEPTH)))
    else $error("insert rejected while table not full");

  a_found_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && found_r) |-> (ocnt_r != '0))
    else $error("entry found in an empty table");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    do_ins |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not advance the count");

endmodule

FILE: sim/tb_stable_sorted_insert_table.sv
// Self-checking testbench for the stable sorted insertion table: stream driver, monitor, predictor.
module tb_stable_sorted_insert_table;
  import sit_pkg::*;

  localparam int DEPTH      = 16;
  localparam int CYCLE_STOP = 400000;   // far beyond the slowest legal run
  localparam int HOLD_LEN   = 90;       // long receiver hold-off, in cycles
  localparam int TAIL_WAIT  = 8;        // settle time after the last result

  // Input beat, declared MSB first so that op lands in bit 0 of tdata.
  typedef struct packed {
    logic [4:0]  position;
    logic        returned_in;
    logic [15:0] loan_ref;
    logic [31:0] date_key;
    op_t         op;
  } req_beat_t;

  // Result beat, declared MSB first so that entry_count lands in bit 0.
  typedef struct packed {
    logic        full_reject;
    logic        returned_out;
    logic [15:0] ref_out;
    logic [31:0] key_out;
    logic        found;
    logic [4:0]  entry_count;
  } resp_beat_t;

  // A queued request plus a flag that makes the driver wait for all results first.
  typedef struct {
    req_beat_t beat;
    bit        drain;
  } queued_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;

  stable_sorted_insert_table uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  queued_req_t queued_ops[$];
  resp_beat_t  due_results[$];

  // Shadow copy of the table contents.
  logic [31:0] shadow_key [DEPTH];
  logic [15:0] shadow_loan[DEPTH];
  logic        shadow_ret [DEPTH];
  int          shadow_cnt = 0;

  int n_total   = 0;
  int n_sent    = 0;   // beats accepted on the input side
  int n_checked = 0;   // result beats accepted on the output side
  int err_cnt   = 0;
  int cycle_cnt = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  int n_ins = 0, n_rej = 0, n_rd = 0, n_hit = 0, n_clr = 0, n_nop = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // Apply one request to the shadow table and return the result it must produce.
  function automatic resp_beat_t table_step(input req_beat_t rq);
    resp_beat_t rs;
    int at;
    int idx;
    rs = '0;
    case (rq.op)
      OP_INSERT: begin
        n_ins++;
        if (shadow_cnt >= DEPTH) begin
          rs.full_reject = 1'b1;
          n_rej++;
        end else begin
          // Land after every key less than or equal, so equal keys keep arrival order.
          at = 0;
          while (at < shadow_cnt && shadow_key[at] <= rq.date_key) at++;
          for (int i = shadow_cnt; i > at; i--) begin
            shadow_key[i]  = shadow_key[i-1];
            shadow_loan[i] = shadow_loan[i-1];
            shadow_ret[i]  = shadow_ret[i-1];
          end
          shadow_key[at]  = rq.date_key;
          shadow_loan[at] = rq.loan_ref;
          shadow_ret[at]  = rq.returned_in;
          shadow_cnt++;
        end
      end
      OP_READ: begin
        n_rd++;
        // Position zero reads the first entry.
        idx = (rq.position == 0) ? 0 : int'(rq.position) - 1;
        if (idx < shadow_cnt) begin
          rs.found        = 1'b1;
          rs.key_out      = shadow_key[idx];
          rs.ref_out      = shadow_loan[idx];
          rs.returned_out = shadow_ret[idx];
          n_hit++;
        end
      end
      OP_CLEAR: begin
        n_clr++;
        shadow_cnt = 0;
      end
      default: n_nop++;
    endcase
    rs.entry_count = shadow_cnt[4:0];
    return rs;
  endfunction

  task automatic add_req(input op_t op, input logic [31:0] key, input logic [15:0] loan,
                         input logic ret, input logic [4:0] pos);
    queued_req_t q;
    q.beat.op          = op;
    q.beat.date_key    = key;
    q.beat.loan_ref    = loan;
    q.beat.returned_in = ret;
    q.beat.position    = pos;
    q.drain            = 1'b0;
    queued_ops.push_back(q);
  endtask

  task automatic flag_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("mismatch on result %0d, %s: expected %0h, got %0h", n_checked, name, want, got);
    end
  endtask

  // Stimulus: directed corner cases, then random bursts.
  initial begin
    logic [31:0] key_base;
    int          kind;
    int          len;
    bit          narrow;

    // Reads of an empty table, including the largest position code.
    add_req(OP_READ, 32'h0, 16'h0, 1'b0, 5'd0);
    add_req(OP_READ, '1, '1, 1'b1, 5'd31);
    // Key extremes and equal keys, whose arrival order must be kept.
    add_req(OP_INSERT, 32'h0000_0000, 16'h0000, 1'b0, 5'd0);
    add_req(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 5'd31);
    add_req(OP_INSERT, 32'h8000_0000, 16'h1234, 1'b1, 5'd0);
    add_req(OP_INSERT, 32'h8000_0000, 16'h5678, 1'b0, 5'd0);
    add_req(OP_INSERT, 32'h0000_0000, 16'hABCD, 1'b1, 5'd0);
    add_req(OP_READ, '1, '1, 1'b1, 5'd0);
    add_req(OP_READ, 32'h0, 16'h0, 1'b0, 5'd2);
    add_req(OP_READ, 32'h0, 16'h0, 1'b0, 5'd3);
    add_req(OP_READ, 32'h0, 16'h0, 1'b0, 5'd6);   // one past the count
    add_req(OP_NOP, '1, '1, 1'b1, 5'd31);
    // Fill to the brim, then insert into a full table.
    for (int i = 0; i < DEPTH - 5; i++)
      add_req(OP_INSERT, $urandom(), 16'($urandom()), 1'($urandom()), 5'd0);
    add_req(OP_INSERT, 32'h4000_0000, 16'hBEEF, 1'b1, 5'd0);
    add_req(OP_READ, 32'h0, 16'h0, 1'b0, 5'd16);
    add_req(OP_READ, 32'h0, 16'h0, 1'b0, 5'd17);
    add_req(OP_CLEAR, '1, '1, 1'b1, 5'd31);
    add_req(OP_READ, 32'h0, 16'h0, 1'b0, 5'd1);

    while (queued_ops.size() < 1250) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        // Insert burst with interleaved reads; a narrow key pool forces ties.
        key_base = $urandom();
        narrow   = ($urandom_range(0, 1) == 1);
        len      = $urandom_range(1, 20);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 3) != 0)
            add_req(OP_INSERT, narrow ? key_base + 32'($urandom_range(0, 3)) : $urandom(),
                    16'($urandom()), 1'($urandom()), 5'($urandom()));
          else
            add_req(OP_READ, $urandom(), 16'($urandom()), 1'($urandom()),
                    5'($urandom_range(0, 17)));
        end
      end else if (kind <= 7) begin
        // Read sweep across and just beyond the held entries.
        len = $urandom_range(2, 18);
        for (int i = 0; i < len; i++)
          add_req(OP_READ, $urandom(), 16'($urandom()), 1'($urandom()),
                  5'($urandom_range(0, 17)));
      end else if (kind == 8) begin
        add_req(OP_CLEAR, $urandom(), 16'($urandom()), 1'($urandom()), 5'($urandom()));
      end else begin
        // Noise: any op code and any field value.
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          add_req(op_t'($urandom_range(0, 3)), $urandom(), 16'($urandom()),
                  1'($urandom()), 5'($urandom()));
      end
    end
    // Pause the sender twice until every result is home.
    queued_ops[400].drain  = 1'b1;
    queued_ops[1100].drain = 1'b1;
    n_total = queued_ops.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (n_sent < n_total || n_checked != n_sent) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    if (due_results.size() != 0) begin
      err_cnt++;
      $display("%0d results never arrived", due_results.size());
    end
    $display("covered %0d beats: %0d inserts (%0d rejected full), %0d reads (%0d hits),",
             n_total, n_ins, n_rej, n_rd, n_hit);
    $display("  %0d clears and %0d no-op beats, under three idle mixes and a long stall",
             n_clr, n_nop);
    if (err_cnt == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Driver: present queued requests, honoring idle gaps and drain points.
  always @(posedge clk) begin
    bit          taken;
    bit          next_valid;
    int          idle_pct;
    queued_req_t q;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      taken      = in_tvalid && in_tready;
      next_valid = in_tvalid;
      if (taken) begin
        due_results.push_back(table_step(in_tdata));
        n_sent <= n_sent + 1;
      end
      // Advance only when no beat is held waiting.
      if (!in_tvalid || taken) begin
        if (n_sent < n_total / 3)            idle_pct = 26;
        else if (n_sent < 2 * n_total / 3)   idle_pct = 67;
        else                                 idle_pct = 0;
        next_valid = 1'b0;
        if (queued_ops.size() > 0 && $urandom_range(0, 99) >= idle_pct &&
            !(queued_ops[0].drain && (taken || n_checked != n_sent))) begin
          q = queued_ops.pop_front();
          in_tdata   <= q.beat;
          next_valid = 1'b1;
        end
      end
      in_tvalid <= next_valid;
    end
  end

  // Long receiver hold-off late in the run, while the sender keeps going.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && n_sent >= (n_total * 4) / 5) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    resp_beat_t got;
    resp_beat_t want;
    int         idle_pct;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (due_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("result %0d arrived with nothing expected", n_checked);
        end else begin
          want = due_results.pop_front();
          flag_field("entry_count",  32'(want.entry_count),  32'(got.entry_count));
          flag_field("found",        32'(want.found),        32'(got.found));
          flag_field("key_out",      want.key_out,           got.key_out);
          flag_field("ref_out",      32'(want.ref_out),      32'(got.ref_out));
          flag_field("returned_out", 32'(want.returned_out), 32'(got.returned_out));
          flag_field("full_reject",  32'(want.full_reject),  32'(got.full_reject));
        end
        n_checked <= n_checked + 1;
      end
      if (n_sent < n_total / 3)            idle_pct = 67;
      else if (n_sent < 2 * n_total / 3)   idle_pct = 26;
      else                                 idle_pct = 0;
      out_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_STOP) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
